>>> hw/rtl/ptg_pkg.sv
// Shared widths, configuration register indexes and control types for the ground-plane projector.
`timescale 1ns / 1ps
package ptg_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int FRAC_BITS  = 16;
    localparam int COEF_W     = 32;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;

    // Coefficient a = u*P20 - P00 and friends.
    localparam int A_W    = PIXEL_BITS + COEF_W + 1;
    // Height term floor(P*h / 2^F) + P.
    localparam int T_W    = 2 * COEF_W - FRAC_BITS + 1;
    // Saturated right-hand side.
    localparam int B_W    = 63;
    localparam int DET_W  = 2 * A_W + 1;
    localparam int NUM_W  = A_W + B_W + 1;
    localparam int DIV_W  = NUM_W + FRAC_BITS;
    localparam int Q_W    = 32;
    localparam int MUL_W  = 64;
    localparam int PROD_W = 2 * MUL_W;

    localparam logic [CFG_IDX_W-1:0] CFG_M00_M01 = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_M02_M03 = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_M10_M11 = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_M12_M13 = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_M20_M21 = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_M22_M23 = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] CFG_GROUND  = CFG_IDX_W'(6);

    typedef struct packed {
        logic neg;
        logic zero;
    } div_ctl_t;

endpackage

>>> hw/rtl/pixel_to_ground_plane.sv
// Top level: back-projects a pixel stream onto the ground plane z = h through a 3x4 camera matrix.
`timescale 1ns / 1ps
// Usage:
//   Input channel: in_valid / in_stall with pixel_col and pixel_row; a beat is taken
//   when in_valid is high and in_stall is low.
//   Output channel: out_valid / out_stall with world_x, world_y (signed Q16.16) and
//   singular, which is set with zero coordinates when the 2x2 system has no solution.
//   Configuration: cfg_valid / cfg_ready with cfg_index (0..6) and cfg_data; cfg_ready is
//   always high. Write only while no pixel is in flight. Indexes above 6 are ignored.
// Timing:
//   An accepted beat passes through the coefficient, height and product stages, then one
//   setup stage, 32 stages of the restoring divider (one quotient bit each), and the output register.
//   Throughput is one pixel per cycle whenever the pipeline is not frozen by a stall.
// Stall:
//   The whole pipeline advances together. It freezes only when the output register holds
//   a beat and out_stall is high; then in_stall is raised and nothing is lost or repeated.
// Reset:
//   rst_n clears all valid bits and every configuration register to zero.
module pixel_to_ground_plane (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [ptg_pkg::PIXEL_BITS-1:0]        pixel_col,
    input  logic [ptg_pkg::PIXEL_BITS-1:0]        pixel_row,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [31:0]                    world_x,
    output logic signed [31:0]                    world_y,
    output logic                                  singular,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ptg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ptg_pkg::CFG_W-1:0]             cfg_data
);
    import ptg_pkg::*;

    localparam int LAT = 44;

    logic signed [COEF_W-1:0] pm_reg [0:11];
    logic signed [COEF_W-1:0] gh_reg;
    logic [LAT-1:0]           valid_reg;
    logic                     en;

    // Stage registers.
    logic [PIXEL_BITS-1:0]    u0_reg, v0_reg, u1_reg, v1_reg, u2_reg, v2_reg;
    logic signed [A_W-1:0]    a00_reg [1:5];
    logic signed [A_W-1:0]    a01_reg [1:5];
    logic signed [A_W-1:0]    a10_reg [1:5];
    logic signed [A_W-1:0]    a11_reg [1:5];
    logic signed [63:0]       ph0_reg, ph1_reg, ph2_reg;
    logic signed [T_W-1:0]    t0_reg [2:4];
    logic signed [T_W-1:0]    t1_reg [2:4];
    logic signed [T_W-1:0]    t2_reg;
    logic signed [B_W-1:0]    b0_reg, b1_reg;
    logic signed [DET_W-1:0]  det_reg [5:8];
    logic signed [NUM_W-1:0]  nx_reg, ny_reg;
    logic [NUM_W-1:0]         nxm_reg, nym_reg;
    logic [DET_W-1:0]         dm_reg;
    div_ctl_t                 ctlx_reg, ctly_reg;

    logic [PROD_W-1:0]        ut2_p, vt2_p, d1_p, d2_p, x1_p, x2_p, y1_p, y2_p;
    logic signed [PROD_W-1:0] rhs0, rhs1;
    logic signed [B_W-1:0]    b0_next, b1_next;
    logic signed [DET_W-1:0]  det_next;
    logic                     zero_y;

    assign en        = !(valid_reg[LAT-1] && out_stall);
    assign in_stall  = !en;
    assign cfg_ready = 1'b1;

    function automatic logic signed [B_W-1:0] sat_rhs(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] lim;
        lim = PROD_W'((128'd1 << (B_W - 1)) - 128'd1);
        if (x > lim)
        begin
            sat_rhs = B_W'(lim);
        end
        else if (x < -lim)
        begin
            sat_rhs = B_W'(-lim);
        end
        else
        begin
            sat_rhs = x[B_W-1:0];
        end
    endfunction

    // Configuration registers; each matrix word carries two entries.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 12; k++)
            begin
                pm_reg[k] <= '0;
            end
            gh_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_M00_M01, CFG_M02_M03, CFG_M10_M11,
                CFG_M12_M13, CFG_M20_M21, CFG_M22_M23:
                begin
                    pm_reg[{cfg_index, 1'b0}] <= cfg_data[31:0];
                    pm_reg[{cfg_index, 1'b1}] <= cfg_data[63:32];
                end
                CFG_GROUND:
                begin
                    gh_reg <= cfg_data[31:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        rhs0     = $signed({{(PROD_W-T_W){t0_reg[4][T_W-1]}}, t0_reg[4]}) - $signed(ut2_p);
        rhs1     = $signed({{(PROD_W-T_W){t1_reg[4][T_W-1]}}, t1_reg[4]}) - $signed(vt2_p);
        b0_next  = sat_rhs(rhs0);
        b1_next  = sat_rhs(rhs1);
        det_next = $signed(d1_p[DET_W-1:0] - d2_p[DET_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Stage 0: capture the pixel.
            u0_reg <= pixel_col;
            v0_reg <= pixel_row;
            // Stage 1: coefficients and the exact height products.
            a00_reg[1] <= A_W'($signed({1'b0, u0_reg}) * pm_reg[8]) - A_W'(pm_reg[0]);
            a01_reg[1] <= A_W'($signed({1'b0, u0_reg}) * pm_reg[9]) - A_W'(pm_reg[1]);
            a10_reg[1] <= A_W'($signed({1'b0, v0_reg}) * pm_reg[8]) - A_W'(pm_reg[4]);
            a11_reg[1] <= A_W'($signed({1'b0, v0_reg}) * pm_reg[9]) - A_W'(pm_reg[5]);
            ph0_reg    <= pm_reg[2] * gh_reg;
            ph1_reg    <= pm_reg[6] * gh_reg;
            ph2_reg    <= pm_reg[10] * gh_reg;
            u1_reg     <= u0_reg;
            v1_reg     <= v0_reg;
            // Stage 2: floor the height products back to Q.F and add the offsets.
            t0_reg[2]  <= T_W'(ph0_reg >>> FRAC_BITS) + T_W'(pm_reg[3]);
            t1_reg[2]  <= T_W'(ph1_reg >>> FRAC_BITS) + T_W'(pm_reg[7]);
            t2_reg     <= T_W'(ph2_reg >>> FRAC_BITS) + T_W'(pm_reg[11]);
            u2_reg     <= u1_reg;
            v2_reg     <= v1_reg;
            for (int s = 2; s <= 5; s++)
            begin
                a00_reg[s] <= a00_reg[s-1];
                a01_reg[s] <= a01_reg[s-1];
                a10_reg[s] <= a10_reg[s-1];
                a11_reg[s] <= a11_reg[s-1];
            end
            t0_reg[3] <= t0_reg[2];
            t0_reg[4] <= t0_reg[3];
            t1_reg[3] <= t1_reg[2];
            t1_reg[4] <= t1_reg[3];
            // Stage 5: right-hand sides and determinant.
            b0_reg     <= b0_next;
            b1_reg     <= b1_next;
            det_reg[5] <= det_next;
            det_reg[6] <= det_reg[5];
            det_reg[7] <= det_reg[6];
            // Stage 8: Cramer numerators.
            nx_reg     <= $signed(x1_p[NUM_W-1:0] - x2_p[NUM_W-1:0]);
            ny_reg     <= $signed(y1_p[NUM_W-1:0] - y2_p[NUM_W-1:0]);
            det_reg[8] <= det_reg[7];
            // Stage 9: magnitudes and signs for the divider.
            nxm_reg        <= nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
            nym_reg        <= ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
            dm_reg         <= det_reg[8][DET_W-1] ? DET_W'(-det_reg[8]) : DET_W'(det_reg[8]);
            ctlx_reg.neg   <= nx_reg[NUM_W-1] ^ det_reg[8][DET_W-1];
            ctly_reg.neg   <= ny_reg[NUM_W-1] ^ det_reg[8][DET_W-1];
            ctlx_reg.zero  <= det_reg[8] == '0;
            ctly_reg.zero  <= det_reg[8] == '0;
        end
    end

    ptg_mul u_mul_ut2 (.clk(clk), .en(en),
        .a($signed({{(MUL_W-PIXEL_BITS){1'b0}}, u2_reg})),
        .b($signed({{(MUL_W-T_W){t2_reg[T_W-1]}}, t2_reg})), .p(ut2_p));
    ptg_mul u_mul_vt2 (.clk(clk), .en(en),
        .a($signed({{(MUL_W-PIXEL_BITS){1'b0}}, v2_reg})),
        .b($signed({{(MUL_W-T_W){t2_reg[T_W-1]}}, t2_reg})), .p(vt2_p));
    ptg_mul u_mul_d1 (.clk(clk), .en(en),
        .a(MUL_W'(a11_reg[2])), .b(MUL_W'(a00_reg[2])), .p(d1_p));
    ptg_mul u_mul_d2 (.clk(clk), .en(en),
        .a(MUL_W'(a01_reg[2])), .b(MUL_W'(a10_reg[2])), .p(d2_p));
    ptg_mul u_mul_x1 (.clk(clk), .en(en),
        .a(MUL_W'(a11_reg[5])), .b(MUL_W'(b0_reg)), .p(x1_p));
    ptg_mul u_mul_x2 (.clk(clk), .en(en),
        .a(MUL_W'(a01_reg[5])), .b(MUL_W'(b1_reg)), .p(x2_p));
    ptg_mul u_mul_y1 (.clk(clk), .en(en),
        .a(MUL_W'(a00_reg[5])), .b(MUL_W'(b1_reg)), .p(y1_p));
    ptg_mul u_mul_y2 (.clk(clk), .en(en),
        .a(MUL_W'(a10_reg[5])), .b(MUL_W'(b0_reg)), .p(y2_p));

    ptg_div u_div_x (.clk(clk), .rst_n(rst_n), .en(en), .n_mag(nxm_reg), .d_mag(dm_reg),
        .ctl(ctlx_reg), .q(world_x), .zero(singular));
    ptg_div u_div_y (.clk(clk), .rst_n(rst_n), .en(en), .n_mag(nym_reg), .d_mag(dm_reg),
        .ctl(ctly_reg), .q(world_y), .zero(zero_y));

    assign out_valid = valid_reg[LAT-1];

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> world_x == 0 && world_y == 0)
        else $error("singular result with nonzero coordinates");

    a_sing_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> singular == zero_y)
        else $error("x and y dividers disagree on singularity");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_reg))
        else $error("pipeline moved while stalled");

    a_accept_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> valid_reg[0])
        else $error("accepted beat did not enter the pipeline");

endmodule

>>> hw/rtl/ptg_mul.sv
// Two-stage signed 64x64 multiplier built from 32-bit partial products.
`timescale 1ns / 1ps
module ptg_mul (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [ptg_pkg::MUL_W-1:0]    a,
    input  logic signed [ptg_pkg::MUL_W-1:0]    b,
    output logic        [ptg_pkg::PROD_W-1:0]   p
);
    import ptg_pkg::*;

    logic        [63:0] pll_reg;
    logic signed [64:0] plh_reg;
    logic signed [64:0] phl_reg;
    logic signed [63:0] phh_reg;
    logic [PROD_W-1:0]  p_reg;
    logic [PROD_W-1:0]  p_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pll_reg <= a[31:0] * b[31:0];
            plh_reg <= $signed({1'b0, a[31:0]}) * $signed(b[63:32]);
            phl_reg <= $signed(a[63:32]) * $signed({1'b0, b[31:0]});
            phh_reg <= $signed(a[63:32]) * $signed(b[63:32]);
            p_reg   <= p_next;
        end
    end

    always_comb
    begin
        p_next = {64'b0, pll_reg}
               + ({{63{plh_reg[64]}}, plh_reg} << 32)
               + ({{63{phl_reg[64]}}, phl_reg} << 32)
               + {phh_reg, 64'b0};
    end

    assign p = p_reg;

endmodule

>>> hw/rtl/ptg_div.sv
// Pipelined restoring divider: one quotient bit per stage, signed saturation at the end.
`timescale 1ns / 1ps
module ptg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic [ptg_pkg::NUM_W-1:0]     n_mag,
    input  logic [ptg_pkg::DET_W-1:0]     d_mag,
    input  ptg_pkg::div_ctl_t             ctl,
    output logic signed [ptg_pkg::Q_W-1:0] q,
    output logic                          zero
);
    import ptg_pkg::*;

    logic [DIV_W-1:0] rem_reg [0:Q_W];
    logic [Q_W-1:0]   q_reg   [0:Q_W];
    logic [DET_W-1:0] d_reg   [0:Q_W];
    div_ctl_t         ctl_reg [0:Q_W];
    logic             ovf_reg [0:Q_W];
    logic [Q_W-1:0]   out_reg;
    logic             zero_reg;
    logic [Q_W-1:0]   out_next;
    logic [Q_W-1:0]   mag;

    // Stage 0: scale the numerator and check whether the quotient overflows 32 bits.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= DIV_W'(n_mag) << FRAC_BITS;
            q_reg[0]   <= '0;
            d_reg[0]   <= d_mag;
            ctl_reg[0] <= ctl;
            ovf_reg[0] <= DIV_W'(n_mag) >= (DIV_W'(d_mag) << (Q_W - FRAC_BITS));
        end
    end

    for (genvar i = 1; i <= Q_W; i++)
    begin : g_step
        logic [DIV_W:0] trial;
        assign trial = {1'b0, rem_reg[i-1]} - {1'b0, DIV_W'(d_reg[i-1]) << (Q_W - i)};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= trial[DIV_W] ? rem_reg[i-1] : trial[DIV_W-1:0];
                q_reg[i]   <= q_reg[i-1] | (Q_W'(!trial[DIV_W]) << (Q_W - i));
                d_reg[i]   <= d_reg[i-1];
                ctl_reg[i] <= ctl_reg[i-1];
                ovf_reg[i] <= ovf_reg[i-1];
            end
        end
    end

    always_comb
    begin
        if (ctl_reg[Q_W].neg)
        begin
            mag = (ovf_reg[Q_W] || q_reg[Q_W] > 32'h8000_0000) ? 32'h8000_0000 : q_reg[Q_W];
            out_next = ~mag + 32'd1;
        end
        else
        begin
            mag = (ovf_reg[Q_W] || q_reg[Q_W] > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_reg[Q_W];
            out_next = mag;
        end
        if (ctl_reg[Q_W].zero)
        begin
            out_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_reg <= 1'b0;
        end
        else if (en)
        begin
            zero_reg <= ctl_reg[Q_W].zero;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign q    = $signed(out_reg);
    assign zero = zero_reg;

endmodule

>>> tb/pixel_to_ground_plane_checker.sv
// Checker for the ground-plane projector: tracks register writes, predicts each result and compares.
`timescale 1ns / 1ps
module pixel_to_ground_plane_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [ptg_pkg::PIXEL_BITS-1:0]    pixel_col,
    input  logic [ptg_pkg::PIXEL_BITS-1:0]    pixel_row,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic signed [31:0]                world_x,
    input  logic signed [31:0]                world_y,
    input  logic                              singular,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [ptg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptg_pkg::CFG_W-1:0]         cfg_data,
    output int                                errors,
    output int                                pending
);
    import ptg_pkg::*;

    localparam int W = 192;
    localparam logic signed [W-1:0] RHS_LIMIT = (W'(1) << 62) - 1;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               sing;
    } ground_point_t;

    logic signed [31:0] cam [12];
    logic signed [31:0] height;
    ground_point_t      expected_points [$];

    function automatic logic signed [W-1:0] clamp_rhs(logic signed [W-1:0] b);
        if (b > RHS_LIMIT)
            return RHS_LIMIT;
        if (b < -RHS_LIMIT)
            return -RHS_LIMIT;
        return b;
    endfunction

    // num * 2^F / det, truncated toward zero and saturated to 32 bits.
    function automatic logic signed [31:0] scaled_ratio(logic signed [W-1:0] num,
                                                        logic signed [W-1:0] det);
        logic             neg;
        logic [W-1:0]     n;
        logic [W-1:0]     d;
        logic [W-1:0]     q;
        neg = num[W-1] ^ det[W-1];
        n = num[W-1] ? -num : num;
        d = det[W-1] ? -det : det;
        q = (n << FRAC_BITS) / d;
        if (neg)
            return (q > W'(32'h8000_0000)) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > W'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    function automatic ground_point_t project_pixel(logic [PIXEL_BITS-1:0] col,
                                                    logic [PIXEL_BITS-1:0] row);
        logic signed [W-1:0] u, v, p [12], h;
        logic signed [W-1:0] a00, a01, a10, a11, t0, t1, t2, b0, b1, det;
        ground_point_t       r;
        u = W'(col);
        v = W'(row);
        for (int k = 0; k < 12; k++)
            p[k] = W'(cam[k]);
        h = W'(height);
        a00 = u * p[8] - p[0];
        a01 = u * p[9] - p[1];
        a10 = v * p[8] - p[4];
        a11 = v * p[9] - p[5];
        t0 = ((p[2] * h) >>> FRAC_BITS) + p[3];
        t1 = ((p[6] * h) >>> FRAC_BITS) + p[7];
        t2 = ((p[10] * h) >>> FRAC_BITS) + p[11];
        b0 = clamp_rhs(t0 - u * t2);
        b1 = clamp_rhs(t1 - v * t2);
        det = a11 * a00 - a01 * a10;
        r.x = '0;
        r.y = '0;
        r.sing = (det == 0);
        if (!r.sing)
        begin
            r.x = scaled_ratio(a11 * b0 - a01 * b1, det);
            r.y = scaled_ratio(a00 * b1 - a10 * b0, det);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ground_point_t e;
        if (!rst_n)
        begin
            for (int k = 0; k < 12; k++)
                cam[k] = '0;
            height = '0;
            expected_points.delete();
            errors = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_GROUND)
                    height = cfg_data[31:0];
                else if (cfg_index <= CFG_M22_M23)
                begin
                    cam[2 * cfg_index]     = cfg_data[31:0];
                    cam[2 * cfg_index + 1] = cfg_data[63:32];
                end
            end
            if (in_valid && !in_stall)
                expected_points.insert(expected_points.size(),
                                       project_pixel(pixel_col, pixel_row));
            if (out_valid && !out_stall)
            begin
                if (expected_points.size() == 0)
                begin
                    $error("result beat with no pixel outstanding");
                    errors++;
                end
                else
                begin
                    e = expected_points.pop_front();
                    if (world_x !== e.x)
                    begin
                        $error("world_x: expected %0d, got %0d", e.x, world_x);
                        errors++;
                    end
                    if (world_y !== e.y)
                    begin
                        $error("world_y: expected %0d, got %0d", e.y, world_y);
                        errors++;
                    end
                    if (singular !== e.sing)
                    begin
                        $error("singular: expected %0d, got %0d", e.sing, singular);
                        errors++;
                    end
                end
            end
            pending = expected_points.size();
        end
    end
endmodule

>>> tb/tb_pixel_to_ground_plane.sv
// Testbench top for the ground-plane projector: register setups, pixel stimulus and verdict.
`timescale 1ns / 1ps
module tb_pixel_to_ground_plane;
    import ptg_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);
    localparam int MAX_WAIT  = 16;
    localparam int SETTLE    = 60;
    localparam int RAND_RUNS = 8;
    localparam int RUN_ITEMS = 200;

    typedef enum int { ENTRY_FULL, ENTRY_CAMERA, ENTRY_EXTREME } entry_kind_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic [PIXEL_BITS-1:0]   pixel_col;
    logic [PIXEL_BITS-1:0]   pixel_row;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      world_x;
    logic signed [31:0]      world_y;
    logic                    singular;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    int                      errors;
    int                      pending;

    // Copies of the block's and checker's outputs taken mid-cycle, so edge logic never races them.
    logic                    in_stall_s;
    logic                    out_valid_s;
    logic                    cfg_ready_s;
    int                      pending_s;
    logic                    calm;
    int                      stall_left = 0;

    pixel_to_ground_plane uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel_col(pixel_col), .pixel_row(pixel_row),
        .out_valid(out_valid), .out_stall(out_stall),
        .world_x(world_x), .world_y(world_y), .singular(singular),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    pixel_to_ground_plane_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .pixel_col(pixel_col), .pixel_row(pixel_row),
        .out_valid(out_valid), .out_stall(out_stall),
        .world_x(world_x), .world_y(world_y), .singular(singular),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        in_stall_s  <= in_stall;
        out_valid_s <= out_valid;
        cfg_ready_s <= cfg_ready;
        pending_s   <= pending;
    end

    // Receiver: after each taken result beat, hold off for a fresh random count.
    always @(posedge clk)
    begin
        int w;
        if (out_valid_s && !out_stall)
        begin
            w = calm ? 0 : $urandom_range(0, MAX_WAIT);
            stall_left <= w;
            out_stall  <= (w != 0);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left > 1);
        end
    end

    task automatic send_pixel(logic [PIXEL_BITS-1:0] col, logic [PIXEL_BITS-1:0] row);
        int gap;
        gap = calm ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        do
            @(posedge clk);
        while (in_stall_s);
    endtask

    // Lowers valid and waits until every result is back and the pipe has emptied.
    task automatic drain_pipe();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_s != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Caller lowers cfg_valid once the whole batch is written.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready_s);
    endtask

    function automatic logic [31:0] pick_entry(entry_kind_t kind);
        case (kind)
            ENTRY_CAMERA:
                return 32'(($signed(32'($urandom_range(0, 131071))) - 65536)
                           <<< $urandom_range(0, 16));
            ENTRY_EXTREME:
                case ($urandom_range(0, 4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            default:
                return $urandom;
        endcase
    endfunction

    task automatic load_matrix(entry_kind_t kind);
        for (int i = 0; i <= CFG_M22_M23; i++)
            cfg_write(CFG_IDX_W'(i), {pick_entry(kind), pick_entry(kind)});
        cfg_write(CFG_GROUND, {32'($urandom), pick_entry(kind)});
        cfg_write(CFG_UNUSED, {32'($urandom), 32'($urandom)});
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_pixel();
        case ($urandom_range(0, 9))
            0: send_pixel($urandom_range(0, 1) ? '1 : '0, PIXEL_BITS'($urandom));
            1: send_pixel(PIXEL_BITS'($urandom), $urandom_range(0, 1) ? '1 : '0);
            default: send_pixel(PIXEL_BITS'($urandom), PIXEL_BITS'($urandom));
        endcase
    endtask

    initial
    begin
        logic [31:0] c;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        pixel_col  = '0;
        pixel_row  = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        calm       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers at reset: every pixel sees a zero determinant.
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('1, '0);
        send_pixel('0, '1);
        drain_pipe();

        // A plausible camera, then the corners and alternating bit patterns.
        load_matrix(ENTRY_CAMERA);
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('1, '0);
        send_pixel('0, '1);
        send_pixel(12'hAAA, 12'h555);
        send_pixel(12'h555, 12'hAAA);
        drain_pipe();

        // Equal upper-left entries with zero M20 and M21 make every system singular.
        c = pick_entry(ENTRY_CAMERA);
        cfg_write(CFG_M00_M01, {c, c});
        cfg_write(CFG_M10_M11, {c, c});
        cfg_write(CFG_M20_M21, '0);
        cfg_valid <= 1'b0;
        send_pixel(12'd17, 12'd900);
        send_pixel('1, '0);
        send_pixel(12'd2048, 12'd2047);
        drain_pipe();

        // Largest magnitudes in all entries but M20 and M21 to push the quotient into saturation.
        cfg_write(CFG_M00_M01, {32'h8000_0000, 32'h7FFF_FFFF});
        cfg_write(CFG_M02_M03, {32'h7FFF_FFFF, 32'h7FFF_FFFF});
        cfg_write(CFG_M10_M11, {32'h7FFF_FFFF, 32'h8000_0000});
        cfg_write(CFG_M12_M13, {32'h8000_0000, 32'h8000_0000});
        cfg_write(CFG_M20_M21, {32'h0000_0001, 32'hFFFF_FFFF});
        cfg_write(CFG_M22_M23, {32'h7FFF_FFFF, 32'h8000_0000});
        cfg_write(CFG_GROUND, {32'h0, 32'h8000_0000});
        cfg_valid <= 1'b0;
        send_pixel('0, '1);
        send_pixel('1, '0);
        send_pixel('1, '1);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'h800, 12'h7FF);
        send_pixel(12'h3C5, 12'hA0F);
        drain_pipe();

        for (int run = 0; run < RAND_RUNS; run++)
        begin
            load_matrix(entry_kind_t'(run % 3));
            calm = (run == 3);
            for (int n = 0; n < RUN_ITEMS; n++)
                random_pixel();
            drain_pipe();
        end
        calm = 1'b0;

        if (errors == 0 && pending_s == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("Verification failed");
        $finish;
    end
endmodule
